/* rtl/bfa_pkg.sv */
package bfa_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_MAX_PROBES  = 16;

    localparam logic [4:0]  PROBE_LIMIT_RESET = 5'd8;
    localparam logic [31:0] HASH_MULT         = 32'h9E37_79B1;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    localparam logic [2:0] ST_FORWARD = 3'd0;
    localparam logic [2:0] ST_REVERSE = 3'd1;
    localparam logic [2:0] ST_INSERT  = 3'd2;
    localparam logic [2:0] ST_DROP    = 3'd3;
    localparam logic [2:0] ST_ENTRY   = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [31:0] router;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  proto;
    } key_t;

    typedef struct packed {
        logic [31:0] first_time;
        logic [63:0] bytes_fwd;
        logic [63:0] bytes_rev;
        logic [31:0] pkts_fwd;
        logic [31:0] pkts_rev;
        logic [31:0] interfaces;
        logic [31:0] as_numbers;
        logic [31:0] flows;
        logic        bidir;
    } data_t;

    typedef struct packed {
        logic start;
        logic done;
    } hash_ctl_t;

endpackage

/* rtl/bfa_ram.sv */
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bfa_hash.sv */
module bfa_hash #(
    parameter int TABLE_DEPTH = bfa_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [31:0]                    router_id,
    input  logic [31:0]                    source_address,
    input  logic [31:0]                    destination_address,
    input  logic [15:0]                    source_port,
    input  logic [15:0]                    destination_port,
    input  logic [7:0]                     protocol_number,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH)-1:0] home
);

    import bfa_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [AW:0] DEPTH_V = (AW + 1)'(TABLE_DEPTH);

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_MUL  = 2'd1;
    localparam logic [1:0] H_MIX  = 2'd2;
    localparam logic [1:0] H_MOD  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [31:0]   x_reg, x_next;
    logic [AW:0]   rem_reg, rem_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [31:0]   folded;
    logic [31:0]   mixed;
    logic [AW:0]   trial;

    always_comb
    begin
        folded = router_id ^ source_address ^ destination_address
               ^ {16'd0, source_port ^ destination_port}
               ^ {8'd0, protocol_number, 16'd0};
        mixed  = x_reg ^ (x_reg >> 15);
        trial  = {rem_reg[AW-1:0], x_reg[31]};
        if (trial >= DEPTH_V)
        begin
            trial = trial - DEPTH_V;
        end

        state_next = state_reg;
        x_next     = x_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    x_next     = folded ^ (folded >> 16);
                    state_next = H_MUL;
                end
            end
            H_MUL:
            begin
                x_next     = x_reg * HASH_MULT;
                state_next = H_MIX;
            end
            H_MIX:
            begin
                x_next   = mixed;
                rem_next = '0;
                cnt_next = 5'd31;
                if (IS_POW2)
                begin
                    rem_next   = {1'b0, mixed[AW-1:0]};
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    state_next = H_MOD;
                end
            end
            H_MOD:
            begin
                rem_next = trial;
                x_next   = {x_reg[30:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign home = rem_reg[AW-1:0];

endmodule

/* rtl/bidirectional_flow_aggregator.sv */
// Channel   Handshake            Moves
// in        in_valid/in_ready    one flow record or drain step per transfer
// out       out_valid/out_ready  one result per transfer
// cfg       cfg_we               probe limit write, no wait
//
// A record is hashed (with a bit-serial reduction when TABLE_DEPTH is not a
// power of two), then the key memory is read across the probe window, then a
// counter update is written and the result is loaded; an insertion or a drop
// skips the counter update.
// A drain step reads the key memory once per slot from the drain pointer on
// until it meets a valid slot.
// After reset a clearing pass writes every slot and so empties the key memory.
// A waiting result is held in the output register while the next item is taken.
module bidirectional_flow_aggregator #(
    parameter int TABLE_DEPTH = bfa_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_PROBES  = bfa_pkg::DEF_MAX_PROBES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [31:0] router_id,
    input  logic [31:0] source_address,
    input  logic [31:0] destination_address,
    input  logic [15:0] source_port,
    input  logic [15:0] destination_port,
    input  logic [7:0]  protocol_number,
    input  logic [31:0] time_stamp,
    input  logic [31:0] byte_count,
    input  logic [31:0] packet_count,
    input  logic [31:0] interface_pair,
    input  logic [31:0] as_pair,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        last,
    output logic [31:0] entry_source_address,
    output logic [31:0] entry_destination_address,
    output logic [31:0] entry_ports,
    output logic [31:0] entry_first_time,
    output logic [63:0] entry_bytes_forward,
    output logic [63:0] entry_bytes_reverse,
    output logic [63:0] entry_packets,
    output logic [31:0] entry_interfaces,
    output logic [31:0] entry_as_numbers,
    output logic [40:0] entry_info,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    import bfa_pkg::*;

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int CW      = (AW + 1 > 7) ? AW + 1 : 7;
    localparam int LIM_CAP = (MAX_PROBES < TABLE_DEPTH) ? MAX_PROBES : TABLE_DEPTH;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
    localparam logic [AW:0]   ONE_OCC   = (AW + 1)'(1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_PROBE = 4'd3;
    localparam logic [3:0] S_DMOD  = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_EMIT  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;

    function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic logic [AW-1:0] next_slot(logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] cmp_slot_reg, cmp_slot_next;
    logic          fwd_hit_reg, fwd_hit_next, rev_hit_reg, rev_hit_next;
    logic          free_hit_reg, free_hit_next;
    logic [AW-1:0] fwd_slot_reg, fwd_slot_next, rev_slot_reg, rev_slot_next;
    logic [AW-1:0] free_slot_reg, free_slot_next;
    logic [AW-1:0] upd_slot_reg, upd_slot_next;
    logic          upd_rev_reg, upd_rev_next;
    logic [AW:0]   occ_reg, occ_next;
    logic [AW-1:0] dptr_reg, dptr_next;
    logic [4:0]    limit_reg;
    logic [2:0]    fin_status_reg, fin_status_next;
    logic          fin_last_reg, fin_last_next;
    logic          out_valid_reg, out_valid_next;

    key_t          in_key_reg;
    logic [31:0]   ts_reg, by_reg, pk_reg, ifp_reg, asp_reg;
    key_t          drain_key_reg, drain_key_next;

    logic [2:0]    status_reg, status_next;
    logic          last_reg, last_next;
    logic [31:0]   e_sa_reg, e_sa_next, e_da_reg, e_da_next, e_ports_reg, e_ports_next;
    logic [31:0]   e_time_reg, e_time_next, e_if_reg, e_if_next, e_as_reg, e_as_next;
    logic [63:0]   e_bf_reg, e_bf_next, e_br_reg, e_br_next, e_pk_reg, e_pk_next;
    logic [40:0]   e_info_reg, e_info_next;

    logic          key_we, data_we;
    logic [AW-1:0] key_waddr, key_raddr, data_waddr, data_raddr;
    key_t          key_wdata, key_rdata;
    data_t         data_wdata, data_rdata, upd;
    logic          hash_start, hash_done;
    logic [AW-1:0] hash_home;
    logic [CW-1:0] n_probe;
    logic          can_emit, accept, fwd_match, rev_match;

    bfa_ram #(.WIDTH($bits(key_t)), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    bfa_ram #(.WIDTH($bits(data_t)), .DEPTH(TABLE_DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    bfa_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (hash_start),
        .router_id           (router_id),
        .source_address      (source_address),
        .destination_address (destination_address),
        .source_port         (source_port),
        .destination_port    (destination_port),
        .protocol_number     (protocol_number),
        .done                (hash_done),
        .home                (hash_home)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign can_emit = !out_valid_reg || out_ready;

    always_comb
    begin
        if (limit_reg == 5'd0)
        begin
            n_probe = CW'(1);
        end
        else if (CW'(limit_reg) > CW'(LIM_CAP))
        begin
            n_probe = CW'(LIM_CAP);
        end
        else
        begin
            n_probe = CW'(limit_reg);
        end

        fwd_match = key_rdata.valid && key_rdata.router == in_key_reg.router
                 && key_rdata.src_addr == in_key_reg.src_addr
                 && key_rdata.dst_addr == in_key_reg.dst_addr
                 && key_rdata.src_port == in_key_reg.src_port
                 && key_rdata.dst_port == in_key_reg.dst_port
                 && key_rdata.proto == in_key_reg.proto;
        rev_match = key_rdata.valid && key_rdata.router == in_key_reg.router
                 && key_rdata.src_addr == in_key_reg.dst_addr
                 && key_rdata.dst_addr == in_key_reg.src_addr
                 && key_rdata.src_port == in_key_reg.dst_port
                 && key_rdata.dst_port == in_key_reg.src_port
                 && key_rdata.proto == in_key_reg.proto;

        upd = data_rdata;
        upd.flows = sat_add32(data_rdata.flows, 32'd1);
        if (upd_rev_reg)
        begin
            upd.bytes_rev = sat_add64(data_rdata.bytes_rev, {32'd0, by_reg});
            upd.pkts_rev  = sat_add32(data_rdata.pkts_rev, pk_reg);
            upd.bidir     = 1'b1;
        end
        else
        begin
            upd.bytes_fwd = sat_add64(data_rdata.bytes_fwd, {32'd0, by_reg});
            upd.pkts_fwd  = sat_add32(data_rdata.pkts_fwd, pk_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        slot_next       = slot_reg;
        pend_next       = pend_reg;
        cmp_slot_next   = cmp_slot_reg;
        fwd_hit_next    = fwd_hit_reg;
        rev_hit_next    = rev_hit_reg;
        free_hit_next   = free_hit_reg;
        fwd_slot_next   = fwd_slot_reg;
        rev_slot_next   = rev_slot_reg;
        free_slot_next  = free_slot_reg;
        upd_slot_next   = upd_slot_reg;
        upd_rev_next    = upd_rev_reg;
        occ_next        = occ_reg;
        dptr_next       = dptr_reg;
        fin_status_next = fin_status_reg;
        fin_last_next   = fin_last_reg;
        drain_key_next  = drain_key_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        status_next  = status_reg;
        last_next    = last_reg;
        e_sa_next    = e_sa_reg;
        e_da_next    = e_da_reg;
        e_ports_next = e_ports_reg;
        e_time_next  = e_time_reg;
        e_bf_next    = e_bf_reg;
        e_br_next    = e_br_reg;
        e_pk_next    = e_pk_reg;
        e_if_next    = e_if_reg;
        e_as_next    = e_as_reg;
        e_info_next  = e_info_reg;

        key_we         = 1'b0;
        key_waddr      = slot_reg;
        key_wdata      = '0;
        key_raddr      = slot_reg;
        data_we        = 1'b0;
        data_waddr     = upd_slot_reg;
        data_wdata     = upd;
        data_raddr     = upd_slot_reg;
        hash_start     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                key_we    = 1'b1;
                slot_next = next_slot(slot_reg);
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_RECORD)
                    begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                    else if (occ_reg == '0)
                    begin
                        dptr_next       = '0;
                        fin_status_next = ST_EMPTY;
                        fin_last_next   = 1'b1;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        slot_next  = dptr_reg;
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    slot_next     = hash_home;
                    cnt_next      = '0;
                    pend_next     = 1'b0;
                    fwd_hit_next  = 1'b0;
                    rev_hit_next  = 1'b0;
                    free_hit_next = 1'b0;
                    state_next    = S_PROBE;
                end
            end
            S_PROBE:
            begin
                pend_next = 1'b0;
                if (cnt_reg < n_probe)
                begin
                    slot_next     = next_slot(slot_reg);
                    cnt_next      = cnt_reg + CW'(1);
                    pend_next     = 1'b1;
                    cmp_slot_next = slot_reg;
                end
                if (pend_reg)
                begin
                    if (fwd_match && !fwd_hit_reg)
                    begin
                        fwd_hit_next  = 1'b1;
                        fwd_slot_next = cmp_slot_reg;
                    end
                    if (rev_match && !rev_hit_reg)
                    begin
                        rev_hit_next  = 1'b1;
                        rev_slot_next = cmp_slot_reg;
                    end
                    if (!key_rdata.valid && !free_hit_reg)
                    begin
                        free_hit_next  = 1'b1;
                        free_slot_next = cmp_slot_reg;
                    end
                end
                else if (cnt_reg == n_probe)
                begin
                    fin_last_next = 1'b0;
                    if (fwd_hit_reg || rev_hit_reg)
                    begin
                        upd_rev_next  = !fwd_hit_reg;
                        upd_slot_next = fwd_hit_reg ? fwd_slot_reg : rev_slot_reg;
                        data_raddr    = upd_slot_next;
                        state_next    = S_DMOD;
                    end
                    else if (free_hit_reg)
                    begin
                        key_we     = 1'b1;
                        key_waddr  = free_slot_reg;
                        key_wdata  = in_key_reg;
                        key_wdata.valid = 1'b1;
                        data_we    = 1'b1;
                        data_waddr = free_slot_reg;
                        data_wdata = '{first_time: ts_reg, bytes_fwd: {32'd0, by_reg},
                                       bytes_rev: 64'd0, pkts_fwd: pk_reg, pkts_rev: 32'd0,
                                       interfaces: ifp_reg, as_numbers: asp_reg,
                                       flows: 32'd1, bidir: 1'b0};
                        occ_next        = occ_reg + ONE_OCC;
                        fin_status_next = ST_INSERT;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        fin_status_next = ST_DROP;
                        state_next      = S_FIN;
                    end
                end
            end
            S_DMOD:
            begin
                data_we         = 1'b1;
                fin_status_next = upd_rev_reg ? ST_REVERSE : ST_FORWARD;
                state_next      = S_FIN;
            end
            S_SCAN:
            begin
                pend_next = 1'b0;
                if (cnt_reg < CW'(TABLE_DEPTH))
                begin
                    slot_next     = next_slot(slot_reg);
                    cnt_next      = cnt_reg + CW'(1);
                    pend_next     = 1'b1;
                    cmp_slot_next = slot_reg;
                end
                if (pend_reg && key_rdata.valid)
                begin
                    upd_slot_next  = cmp_slot_reg;
                    drain_key_next = key_rdata;
                    data_raddr     = cmp_slot_reg;
                    state_next     = S_EMIT;
                end
                else if (!pend_reg && cnt_reg == CW'(TABLE_DEPTH))
                begin
                    occ_next        = '0;
                    dptr_next       = '0;
                    fin_status_next = ST_EMPTY;
                    fin_last_next   = 1'b1;
                    state_next      = S_FIN;
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_ENTRY;
                    e_sa_next      = drain_key_reg.src_addr;
                    e_da_next      = drain_key_reg.dst_addr;
                    e_ports_next   = {drain_key_reg.src_port, drain_key_reg.dst_port};
                    e_time_next    = data_rdata.first_time;
                    e_bf_next      = data_rdata.bytes_fwd;
                    e_br_next      = data_rdata.bytes_rev;
                    e_pk_next      = {data_rdata.pkts_fwd, data_rdata.pkts_rev};
                    e_if_next      = data_rdata.interfaces;
                    e_as_next      = data_rdata.as_numbers;
                    e_info_next    = {data_rdata.flows, data_rdata.bidir, drain_key_reg.proto};
                    key_we         = 1'b1;
                    key_waddr      = upd_slot_reg;
                    occ_next       = occ_reg - ONE_OCC;
                    if (occ_reg == ONE_OCC)
                    begin
                        dptr_next = '0;
                        last_next = 1'b1;
                    end
                    else
                    begin
                        dptr_next = next_slot(upd_slot_reg);
                        last_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = fin_status_reg;
                    last_next      = fin_last_reg;
                    e_sa_next      = '0;
                    e_da_next      = '0;
                    e_ports_next   = '0;
                    e_time_next    = '0;
                    e_bf_next      = '0;
                    e_br_next      = '0;
                    e_pk_next      = '0;
                    e_if_next      = '0;
                    e_as_next      = '0;
                    e_info_next    = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            pend_reg      <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            rev_hit_reg   <= 1'b0;
            free_hit_reg  <= 1'b0;
            upd_rev_reg   <= 1'b0;
            occ_reg       <= '0;
            dptr_reg      <= '0;
            limit_reg     <= PROBE_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            fwd_hit_reg   <= fwd_hit_next;
            rev_hit_reg   <= rev_hit_next;
            free_hit_reg  <= free_hit_next;
            upd_rev_reg   <= upd_rev_next;
            occ_reg       <= occ_next;
            dptr_reg      <= dptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_key_reg <= '{valid: 1'b1, router: router_id, src_addr: source_address,
                            dst_addr: destination_address, src_port: source_port,
                            dst_port: destination_port, proto: protocol_number};
            ts_reg     <= time_stamp;
            by_reg     <= byte_count;
            pk_reg     <= packet_count;
            ifp_reg    <= interface_pair;
            asp_reg    <= as_pair;
        end
        cmp_slot_reg   <= cmp_slot_next;
        fwd_slot_reg   <= fwd_slot_next;
        rev_slot_reg   <= rev_slot_next;
        free_slot_reg  <= free_slot_next;
        upd_slot_reg   <= upd_slot_next;
        fin_status_reg <= fin_status_next;
        fin_last_reg   <= fin_last_next;
        drain_key_reg  <= drain_key_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
        e_sa_reg       <= e_sa_next;
        e_da_reg       <= e_da_next;
        e_ports_reg    <= e_ports_next;
        e_time_reg     <= e_time_next;
        e_bf_reg       <= e_bf_next;
        e_br_reg       <= e_br_next;
        e_pk_reg       <= e_pk_next;
        e_if_reg       <= e_if_next;
        e_as_reg       <= e_as_next;
        e_info_reg     <= e_info_next;
    end

    assign out_valid                 = out_valid_reg;
    assign status                    = status_reg;
    assign last                      = last_reg;
    assign entry_source_address      = e_sa_reg;
    assign entry_destination_address = e_da_reg;
    assign entry_ports               = e_ports_reg;
    assign entry_first_time          = e_time_reg;
    assign entry_bytes_forward       = e_bf_reg;
    assign entry_bytes_reverse       = e_br_reg;
    assign entry_packets             = e_pk_reg;
    assign entry_interfaces          = e_if_reg;
    assign entry_as_numbers          = e_as_reg;
    assign entry_info                = e_info_reg;

    // The occupancy can never exceed the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= (AW + 1)'(TABLE_DEPTH))
        else $error("occupancy beyond table depth");

    // No item is taken while the clearing pass is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ready)
        else $error("item taken during clearing pass");

    // A result that empties the table leaves the drain pointer at the start.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> dptr_reg == '0)
        else $error("drain pointer not reset after last entry");

    // Only a drained entry carries entry fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_ENTRY |-> e_info_reg == '0 && e_bf_reg == '0)
        else $error("entry fields set on a non-drain result");

    // A freshly loaded result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(status_reg) && $stable(e_info_reg))
        else $error("waiting result overwritten");

endmodule

/* tb/flow_cache_checker.sv */
module flow_cache_checker
    import bfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [31:0] router_id,
    input  logic [31:0] source_address,
    input  logic [31:0] destination_address,
    input  logic [15:0] source_port,
    input  logic [15:0] destination_port,
    input  logic [7:0]  protocol_number,
    input  logic [31:0] time_stamp,
    input  logic [31:0] byte_count,
    input  logic [31:0] packet_count,
    input  logic [31:0] interface_pair,
    input  logic [31:0] as_pair,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic        last,
    input  logic [31:0] entry_source_address,
    input  logic [31:0] entry_destination_address,
    input  logic [31:0] entry_ports,
    input  logic [31:0] entry_first_time,
    input  logic [63:0] entry_bytes_forward,
    input  logic [63:0] entry_bytes_reverse,
    input  logic [63:0] entry_packets,
    input  logic [31:0] entry_interfaces,
    input  logic [31:0] entry_as_numbers,
    input  logic [40:0] entry_info,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    output int          mismatches,
    output int          pending
);

    localparam int DEPTH = DEF_TABLE_DEPTH;

    typedef struct {
        logic [2:0]  status;
        logic        last;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] ports;
        logic [31:0] first_time;
        logic [63:0] bytes_fwd;
        logic [63:0] bytes_rev;
        logic [63:0] packets;
        logic [31:0] interfaces;
        logic [31:0] as_numbers;
        logic [40:0] info;
    } flow_result_t;

    flow_result_t awaited_results[$];

    logic        used[DEPTH];
    logic [31:0] t_router[DEPTH];
    logic [31:0] t_src[DEPTH];
    logic [31:0] t_dst[DEPTH];
    logic [15:0] t_sport[DEPTH];
    logic [15:0] t_dport[DEPTH];
    logic [7:0]  t_proto[DEPTH];
    logic [31:0] t_first[DEPTH];
    logic [63:0] t_bfwd[DEPTH];
    logic [63:0] t_brev[DEPTH];
    logic [31:0] t_pfwd[DEPTH];
    logic [31:0] t_prev[DEPTH];
    logic [31:0] t_ifs[DEPTH];
    logic [31:0] t_as[DEPTH];
    logic [31:0] t_flows[DEPTH];
    logic        t_bidir[DEPTH];
    int          drain_at;
    int          occupancy;
    logic [4:0]  window_reg;

    function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [63:0] sat64(logic [63:0] a, logic [31:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {33'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic int home_of(logic [31:0] r, logic [31:0] sa, logic [31:0] da,
                                   logic [15:0] sp, logic [15:0] dp, logic [7:0] pr);
        logic [31:0] x;
        x = r ^ sa ^ da ^ {16'b0, sp ^ dp} ^ {8'b0, pr, 16'b0};
        x = x ^ (x >> 16);
        x = x * HASH_MULT;
        x = x ^ (x >> 15);
        return int'(x % DEPTH);
    endfunction

    function automatic int lookup(int start, int n, logic [31:0] r, logic [31:0] sa,
                                  logic [31:0] da, logic [15:0] sp, logic [15:0] dp,
                                  logic [7:0] pr);
        int s;
        for (int i = 0; i < n; i++)
        begin
            s = (start + i) % DEPTH;
            if (used[s] && t_router[s] == r && t_src[s] == sa && t_dst[s] == da &&
                t_sport[s] == sp && t_dport[s] == dp && t_proto[s] == pr)
                return s;
        end
        return -1;
    endfunction

    task automatic predict_flow_result();
        flow_result_t res;
        int home;
        int n;
        int s;
        res = '{default: '0};
        if (kind == KIND_RECORD)
        begin
            home = home_of(router_id, source_address, destination_address,
                           source_port, destination_port, protocol_number);
            n = (window_reg == 0) ? 1 : ((window_reg > DEF_MAX_PROBES) ? DEF_MAX_PROBES
                                                                      : int'(window_reg));
            s = lookup(home, n, router_id, source_address, destination_address,
                       source_port, destination_port, protocol_number);
            if (s >= 0)
            begin
                t_bfwd[s] = sat64(t_bfwd[s], byte_count);
                t_pfwd[s] = sat32(t_pfwd[s], packet_count);
                t_flows[s] = sat32(t_flows[s], 32'd1);
                res.status = ST_FORWARD;
            end
            else
            begin
                s = lookup(home, n, router_id, destination_address, source_address,
                           destination_port, source_port, protocol_number);
                if (s >= 0)
                begin
                    t_brev[s] = sat64(t_brev[s], byte_count);
                    t_prev[s] = sat32(t_prev[s], packet_count);
                    t_flows[s] = sat32(t_flows[s], 32'd1);
                    t_bidir[s] = 1'b1;
                    res.status = ST_REVERSE;
                end
                else
                begin
                    res.status = ST_DROP;
                    for (int i = 0; i < n; i++)
                    begin
                        s = (home + i) % DEPTH;
                        if (!used[s])
                        begin
                            used[s] = 1'b1;
                            t_router[s] = router_id;
                            t_src[s] = source_address;
                            t_dst[s] = destination_address;
                            t_sport[s] = source_port;
                            t_dport[s] = destination_port;
                            t_proto[s] = protocol_number;
                            t_first[s] = time_stamp;
                            t_bfwd[s] = {32'b0, byte_count};
                            t_brev[s] = '0;
                            t_pfwd[s] = packet_count;
                            t_prev[s] = '0;
                            t_ifs[s] = interface_pair;
                            t_as[s] = as_pair;
                            t_flows[s] = 32'd1;
                            t_bidir[s] = 1'b0;
                            occupancy++;
                            res.status = ST_INSERT;
                            break;
                        end
                    end
                end
            end
        end
        else if (occupancy == 0)
        begin
            drain_at = 0;
            res.status = ST_EMPTY;
            res.last = 1'b1;
        end
        else
        begin
            res.status = ST_EMPTY;
            res.last = 1'b1;
            for (int i = 0; i < DEPTH; i++)
            begin
                s = (drain_at + i) % DEPTH;
                if (used[s])
                begin
                    res.status = ST_ENTRY;
                    res.last = 1'b0;
                    res.src = t_src[s];
                    res.dst = t_dst[s];
                    res.ports = {t_sport[s], t_dport[s]};
                    res.first_time = t_first[s];
                    res.bytes_fwd = t_bfwd[s];
                    res.bytes_rev = t_brev[s];
                    res.packets = {t_pfwd[s], t_prev[s]};
                    res.interfaces = t_ifs[s];
                    res.as_numbers = t_as[s];
                    res.info = {t_flows[s], t_bidir[s], t_proto[s]};
                    used[s] = 1'b0;
                    occupancy--;
                    drain_at = (s + 1) % DEPTH;
                    if (occupancy == 0)
                    begin
                        drain_at = 0;
                        res.last = 1'b1;
                    end
                    break;
                end
            end
            if (res.status == ST_EMPTY)
            begin
                occupancy = 0;
                drain_at = 0;
            end
        end
        awaited_results.push_back(res);
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s is %h, expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic check_flow_result();
        flow_result_t w;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("unexpected result, status", 64'(status), 64'hx);
            return;
        end
        w = awaited_results.pop_front();
        if (status !== w.status) report_mismatch("status", 64'(status), 64'(w.status));
        if (last !== w.last) report_mismatch("last", 64'(last), 64'(w.last));
        if (entry_source_address !== w.src)
            report_mismatch("entry_source_address", 64'(entry_source_address), 64'(w.src));
        if (entry_destination_address !== w.dst)
            report_mismatch("entry_destination_address", 64'(entry_destination_address),
                            64'(w.dst));
        if (entry_ports !== w.ports)
            report_mismatch("entry_ports", 64'(entry_ports), 64'(w.ports));
        if (entry_first_time !== w.first_time)
            report_mismatch("entry_first_time", 64'(entry_first_time), 64'(w.first_time));
        if (entry_bytes_forward !== w.bytes_fwd)
            report_mismatch("entry_bytes_forward", entry_bytes_forward, w.bytes_fwd);
        if (entry_bytes_reverse !== w.bytes_rev)
            report_mismatch("entry_bytes_reverse", entry_bytes_reverse, w.bytes_rev);
        if (entry_packets !== w.packets)
            report_mismatch("entry_packets", entry_packets, w.packets);
        if (entry_interfaces !== w.interfaces)
            report_mismatch("entry_interfaces", 64'(entry_interfaces), 64'(w.interfaces));
        if (entry_as_numbers !== w.as_numbers)
            report_mismatch("entry_as_numbers", 64'(entry_as_numbers), 64'(w.as_numbers));
        if (entry_info !== w.info)
            report_mismatch("entry_info", 64'(entry_info), 64'(w.info));
    endtask

    initial
    begin
        mismatches = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                used[i] = 1'b0;
            drain_at = 0;
            occupancy = 0;
            window_reg = PROBE_LIMIT_RESET;
            awaited_results.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                predict_flow_result();
            if (out_valid && out_ready)
                check_flow_result();
            if (cfg_we)
                window_reg = cfg_wdata;
        end
        pending = awaited_results.size();
    end

endmodule

/* tb/bidirectional_flow_aggregator_tb.sv */
module bidirectional_flow_aggregator_tb;
    import bfa_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic        kind;
        logic [31:0] router;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [31:0] stamp;
        logic [31:0] bytes;
        logic [31:0] pkts;
        logic [31:0] ifs;
        logic [31:0] asn;
    } flow_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [31:0] router_id;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol_number;
    logic [31:0] time_stamp;
    logic [31:0] byte_count;
    logic [31:0] packet_count;
    logic [31:0] interface_pair;
    logic [31:0] as_pair;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic        last;
    logic [31:0] entry_source_address;
    logic [31:0] entry_destination_address;
    logic [31:0] entry_ports;
    logic [31:0] entry_first_time;
    logic [63:0] entry_bytes_forward;
    logic [63:0] entry_bytes_reverse;
    logic [63:0] entry_packets;
    logic [31:0] entry_interfaces;
    logic [31:0] entry_as_numbers;
    logic [40:0] entry_info;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    int          mismatches;
    int          pending;

    int          idle_cycles;
    int          burst_left;
    int          long_bursts;
    int          records_sent;
    int          drains_sent;
    int          stall_mode;
    flow_item_t  key_pool[32];

    bidirectional_flow_aggregator uut (.*);

    flow_cache_checker checker_i (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        stall_mode <= ($urandom_range(0, 199) == 0) ? $urandom_range(0, 3) : stall_mode;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 1) != 0);
            default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input flow_item_t it);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = long_bursts ? $urandom_range(20, 60) : $urandom_range(1, 8);
        end
        in_valid            <= 1'b1;
        kind                <= it.kind;
        router_id           <= it.router;
        source_address      <= it.src;
        destination_address <= it.dst;
        source_port         <= it.sport;
        destination_port    <= it.dport;
        protocol_number     <= it.proto;
        time_stamp          <= it.stamp;
        byte_count          <= it.bytes;
        packet_count        <= it.pkts;
        interface_pair      <= it.ifs;
        as_pair             <= it.asn;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        if (it.kind == KIND_DRAIN)
            drains_sent++;
        else
            records_sent++;
    endtask

    task automatic settle_and_write(input logic [4:0] limit);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic flow_item_t swapped(input flow_item_t it);
        flow_item_t r;
        r = it;
        r.src = it.dst;
        r.dst = it.src;
        r.sport = it.dport;
        r.dport = it.sport;
        return r;
    endfunction

    function automatic flow_item_t random_record();
        flow_item_t r;
        r.kind = KIND_RECORD;
        r.router = $urandom();
        r.src = $urandom();
        r.dst = $urandom();
        r.sport = 16'($urandom());
        r.dport = 16'($urandom());
        r.proto = 8'($urandom());
        r.stamp = $urandom();
        r.bytes = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom();
        r.pkts = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : $urandom();
        r.ifs = $urandom();
        r.asn = $urandom();
        return r;
    endfunction

    function automatic flow_item_t drain_step();
        flow_item_t r;
        r = random_record();
        r.kind = KIND_DRAIN;
        return r;
    endfunction

    // The first half of the pool shares one home slot: router and source address
    // vary together, so the XOR of the key stays the same.
    task automatic build_pool();
        flow_item_t seed_key;
        logic [31:0] m;
        seed_key = random_record();
        for (int i = 0; i < 32; i++)
        begin
            key_pool[i] = random_record();
            if (i < 16)
            begin
                m = $urandom();
                key_pool[i] = seed_key;
                key_pool[i].router = seed_key.router ^ m;
                key_pool[i].src = seed_key.src ^ m;
            end
        end
    endtask

    task automatic run_random(input int count);
        flow_item_t it;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if ((n % 50) == 0)
                long_bursts = $urandom_range(0, 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_item(drain_step());
            else if (pick < 10)
            begin
                repeat ($urandom_range(10, 40)) send_item(drain_step());
            end
            else if (pick < 20)
                send_item(random_record());
            else
            begin
                it = key_pool[$urandom_range(0, 31)];
                it.stamp = $urandom();
                it.bytes = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom();
                it.pkts = ($urandom_range(0, 6) == 0) ? 32'hFFFF_FFFF : $urandom();
                it.ifs = $urandom();
                it.asn = $urandom();
                if ($urandom_range(0, 2) == 0)
                    it = swapped(it);
                send_item(it);
            end
        end
    endtask

    initial
    begin
        flow_item_t it;
        flow_item_t ones;
        logic [4:0] limits[6];
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        stall_mode = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        kind = KIND_RECORD;
        router_id = '0;
        source_address = '0;
        destination_address = '0;
        source_port = '0;
        destination_port = '0;
        protocol_number = '0;
        time_stamp = '0;
        byte_count = '0;
        packet_count = '0;
        interface_pair = '0;
        as_pair = '0;
        idle_cycles = 0;
        burst_left = 0;
        long_bursts = 0;
        records_sent = 0;
        drains_sent = 0;
        limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd8};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_item(drain_step());
        ones = '{KIND_RECORD, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1};
        send_item(ones);
        send_item(ones);
        send_item(ones);
        it = swapped(ones);
        it.src = 32'h0;
        it.sport = 16'h0;
        send_item(it);
        it = swapped(it);
        send_item(it);
        send_item(it);
        it = '{default: '0};
        send_item(it);
        send_item(it);
        build_pool();
        for (int i = 0; i < 10; i++)
            send_item(key_pool[i]);
        send_item(swapped(key_pool[2]));
        repeat (3) send_item(drain_step());
        send_item(key_pool[10]);
        repeat (16) send_item(drain_step());

        foreach (limits[p])
        begin
            settle_and_write(limits[p]);
            build_pool();
            run_random(100);
        end
        repeat (40) send_item(drain_step());

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d flow records and %0d drain steps over probe limits",
                 records_sent, drains_sent);
        $display("from 0 to 31, with colliding keys, reverse merges and saturation");
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
